### rtl/wsfd_pkg.sv
// Package for the WebSocket frame deframer.
// Result type, result kinds, error codes and frame header constants.
// No dependencies.
`default_nettype none

package wsfd_pkg;

    localparam int unsigned CFG_W = 17;
    localparam logic [CFG_W-1:0] CFG_RESET = 17'h10000;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RESERVED  = 3'd1,
        ERR_CONTROL   = 3'd2,
        ERR_TOO_LARGE = 3'd3,
        ERR_OPCODE    = 3'd4
    } err_t;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
    localparam logic [6:0] LEN_EXT16    = 7'd126;
    localparam logic [6:0] LEN_EXT64    = 7'd127;

    localparam logic [2:0] EXT16_BYTES_LEFT = 3'd1;
    localparam logic [2:0] EXT64_BYTES_LEFT = 3'd7;
    localparam logic [2:0] MASK_BYTES_LEFT  = 3'd3;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic       was_masked;
        logic       last_of_frame;
        err_t       error_code;
    } result_t;

endpackage

`default_nettype wire

### rtl/websocket_frame_deframer_unit.sv
// WebSocket frame deframer top level: input register, parser, result register
// and the payload limit register. Uses wsfd_pkg and wsfd_parser.
//
// Takes one received byte per transaction on the s_ side and yields payload
// bytes unmasked, an empty-frame marker or an error code on the m_ side. A taken
// byte is held in the input register and parsed from there; its result is
// loaded into the result register when that register is free or being taken.
// A new byte is taken every cycle while m_tready holds; header bytes give no
// result unless they close an empty frame or raise an error.
// After any error the block swallows all input until rst_n. The payload limit
// is the smaller of cfg_wdata (reset 65536) and MAX_FRAME_LIMIT; write it only
// while the block is idle between frames.
`default_nettype none

module websocket_frame_deframer_unit #(
    parameter int unsigned MAX_FRAME_LIMIT = 65536
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire  [wsfd_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // [7:0] data_byte, [8] fin_flag, [12:9] frame_opcode, [13] was_masked,
    // [16:14] error_code, [23:17] zero
    output logic [23:0]                 m_tdata,
    output logic [1:0]                  m_tuser,   // [1:0] kind
    output logic                        m_tlast
);

    logic                          in_valid_reg, in_valid_next;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg, out_valid_next;
    wsfd_pkg::result_t             out_res_reg;
    logic [wsfd_pkg::CFG_W-1:0]    limit_reg;
    logic                          out_free;
    logic                          step;
    logic                          res_valid;
    wsfd_pkg::result_t             res;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        if (out_free)
        begin
            out_valid_next = step && res_valid;
        end
    end

    wsfd_parser #(
        .MAX_FRAME_LIMIT (MAX_FRAME_LIMIT)
    ) u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .rx_byte           (in_byte_reg),
        .max_payload_bytes (limit_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= wsfd_pkg::CFG_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (out_free && step && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.error_code, out_res_reg.was_masked,
                       out_res_reg.frame_opcode, out_res_reg.fin_flag,
                       out_res_reg.data_byte};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last_of_frame;

endmodule

`default_nettype wire

### rtl/wsfd_parser.sv
// Frame header parser and payload unmasker: holds the per-frame state and
// turns one received byte into at most one result. Uses wsfd_pkg.
`default_nettype none

module wsfd_parser #(
    parameter int unsigned MAX_FRAME_LIMIT = 65536
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          step,
    input  wire  [7:0]                   rx_byte,
    input  wire  [wsfd_pkg::CFG_W-1:0]   max_payload_bytes,
    output logic                         res_valid,
    output wsfd_pkg::result_t            res
);

    localparam int unsigned LW = $clog2(MAX_FRAME_LIMIT + 1);
    localparam int unsigned CW = (LW > wsfd_pkg::CFG_W) ? LW : wsfd_pkg::CFG_W;
    localparam logic [LW-1:0] LIMIT_MAX = LW'(MAX_FRAME_LIMIT);

    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_LEN,
        PH_EXT,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [3:0]  op_reg, op_next;
    logic        masked_reg, masked_next;
    logic [LW-1:0] len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic [2:0]  hbc_reg, hbc_next;
    logic [31:0] key_reg, key_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic        halted_reg, halted_next;

    logic [LW+7:0] len_shift;
    logic [LW:0]   idx_inc;
    logic [6:0]    len7;
    logic          len_done;
    logic          hdr_done;
    logic          too_large;
    logic          op_ok;
    logic [7:0]    key_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        hbc_next    = hbc_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        len7        = rx_byte[6:0];
        len_shift   = {len_reg, rx_byte};
        idx_inc     = {1'b0, idx_reg} + (LW+1)'(1);
        key_byte    = key_reg[(5'd24 - {idx_reg[1:0], 3'b000}) +: 8];

        if (step && !halted_reg)
        begin
            case (phase_reg)
                PH_FLAGS:
                begin
                    if (rx_byte[6:4] != 3'b000)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = wsfd_pkg::KIND_ERROR;
                        res.error_code   = wsfd_pkg::ERR_RESERVED;
                        halted_next      = 1'b1;
                    end
                    else
                    begin
                        fin_next   = rx_byte[7];
                        op_next    = rx_byte[3:0];
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    masked_next = rx_byte[7];
                    if (op_reg[3] && (!fin_reg || len7 > wsfd_pkg::LEN_CTRL_MAX))
                    begin
                        res_valid      = 1'b1;
                        res.kind       = wsfd_pkg::KIND_ERROR;
                        res.error_code = wsfd_pkg::ERR_CONTROL;
                        halted_next    = 1'b1;
                        phase_next     = PH_FLAGS;
                    end
                    else if (len7 == wsfd_pkg::LEN_EXT16)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        hbc_next   = wsfd_pkg::EXT16_BYTES_LEFT;
                        phase_next = PH_EXT;
                    end
                    else if (len7 == wsfd_pkg::LEN_EXT64)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        hbc_next   = wsfd_pkg::EXT64_BYTES_LEFT;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        len_next = LW'(len7);
                        ovf_next = 1'b0;
                        len_done = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    len_next = len_shift[LW-1:0];
                    ovf_next = ovf_reg || (len_shift[LW+7:LW] != 8'h00);
                    if (hbc_reg == 3'd0)
                    begin
                        len_done = 1'b1;
                    end
                    else
                    begin
                        hbc_next = hbc_reg - 3'd1;
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (hbc_reg == 3'd0)
                    begin
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        hbc_next = hbc_reg - 3'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid         = 1'b1;
                    res.kind          = wsfd_pkg::KIND_PAYLOAD;
                    res.data_byte     = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    res.fin_flag      = fin_reg;
                    res.frame_opcode  = op_reg;
                    res.was_masked    = masked_reg;
                    res.last_of_frame = (idx_inc >= {1'b0, len_reg});
                    idx_next          = idx_inc[LW-1:0];
                    if (res.last_of_frame)
                    begin
                        phase_next = PH_FLAGS;
                    end
                end
                default:
                begin
                    phase_next = PH_FLAGS;
                end
            endcase
        end

        too_large = ovf_next
                 || (CW'(len_next) > CW'(max_payload_bytes))
                 || (len_next > LIMIT_MAX);

        if (len_done)
        begin
            if (too_large)
            begin
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = wsfd_pkg::KIND_ERROR;
                res.error_code = wsfd_pkg::ERR_TOO_LARGE;
                halted_next    = 1'b1;
                phase_next     = PH_FLAGS;
            end
            else if (masked_next)
            begin
                key_next   = '0;
                hbc_next   = wsfd_pkg::MASK_BYTES_LEFT;
                phase_next = PH_MASK;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        op_ok = (op_reg == wsfd_pkg::OP_CONT) || (op_reg == wsfd_pkg::OP_TEXT)
             || (op_reg == wsfd_pkg::OP_CLOSE) || (op_reg == wsfd_pkg::OP_PING)
             || (op_reg == wsfd_pkg::OP_PONG);

        if (hdr_done)
        begin
            res_valid = 1'b1;
            res       = '0;
            if (!op_ok)
            begin
                res.kind       = wsfd_pkg::KIND_ERROR;
                res.error_code = wsfd_pkg::ERR_OPCODE;
                halted_next    = 1'b1;
                phase_next     = PH_FLAGS;
            end
            else
            begin
                idx_next = '0;
                if (len_next == '0)
                begin
                    res.kind          = wsfd_pkg::KIND_EMPTY;
                    res.fin_flag      = fin_reg;
                    res.frame_opcode  = op_reg;
                    res.was_masked    = masked_next;
                    res.last_of_frame = 1'b1;
                    phase_next        = PH_FLAGS;
                end
                else
                begin
                    res_valid  = 1'b0;
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FLAGS;
            fin_reg    <= 1'b0;
            op_reg     <= 4'h0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            hbc_reg    <= 3'd0;
            key_reg    <= '0;
            idx_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            hbc_reg    <= hbc_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire
